// File: design/depth_pixel_to_world_point_defines.svh
// Assertion helpers for the RTL that checks itself.
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_DEFINES_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define DPW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define DPW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dpw_pkg;

    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 360;

    // Pipeline: stages 0..3 build the camera point, 4..6 the world point.
    localparam int STAGES     = 7;
    localparam int POSE_WORDS = 12;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_POSE  = 1'b1;

    localparam logic [2:0] CFG_INV_FOCAL_X     = 3'd0;
    localparam logic [2:0] CFG_INV_FOCAL_Y     = 3'd1;
    localparam logic [2:0] CFG_CENTER_X        = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y        = 3'd3;
    localparam logic [2:0] CFG_INV_DEPTH_SCALE = 3'd4;

    localparam logic [23:0] RST_INV_FOCAL     = 24'd51619;
    localparam logic [15:0] RST_CENTER_X      = 16'd5068;
    localparam logic [15:0] RST_CENTER_Y      = 16'd2896;
    localparam logic [23:0] RST_INV_DEPTH_SCL = 24'd16777;

    typedef struct packed {
        logic [STAGES-1:0] adv;
        logic [STAGES-1:0] vld;
    } pipe_ctl_t;

    typedef struct packed {
        logic [23:0] inv_focal_x;
        logic [23:0] inv_focal_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [23:0] inv_depth_scale;
    } cam_cfg_t;

    typedef struct packed {
        logic        wr;
        logic [3:0]  idx;
        logic [31:0] value;
    } pose_wr_t;

endpackage
`default_nettype wire

// File: design/dpw_cam.sv
`timescale 1ns / 1ps
`default_nettype none
module dpw_cam (
    input  wire logic                    aclk,
    input  wire dpw_pkg::pipe_ctl_t      ctl,
    input  wire dpw_pkg::cam_cfg_t       cfg,
    input  wire dpw_pkg::pose_wr_t       pw_in,
    input  wire logic [15:0]             depth_raw,
    input  wire logic [9:0]              pixel_col,
    input  wire logic [8:0]              pixel_row,
    output logic signed [31:0]           cam_x,
    output logic signed [31:0]           cam_y,
    output logic signed [31:0]           cam_z,
    output dpw_pkg::pose_wr_t            pw_out
);
    import dpw_pkg::*;

    // {sign, magnitude} of a Q12.4 pixel offset from the principal point
    function automatic logic [16:0] pix_offset(input logic [13:0] pix16,
                                               input logic [15:0] center);
        logic [16:0] d;
        logic [16:0] nd;
        d  = {3'b000, pix16} - {1'b0, center};
        nd = 17'd0 - d;
        pix_offset = d[16] ? {1'b1, nd[15:0]} : {1'b0, d[15:0]};
    endfunction

    // (hi*2^32 + lo + 2^35) >> 36, then sign and saturate to 32 bits
    function automatic logic signed [31:0] round_sat(input logic [47:0] hi,
                                                     input logic [55:0] lo,
                                                     input logic neg);
        logic [80:0] sum;
        logic [44:0] r;
        logic [31:0] nr;
        sum = {1'b0, hi, 32'd0} + {25'd0, lo} + (81'd1 << 35);
        r   = sum[80:36];
        nr  = 32'd0 - r[31:0];
        if (neg) begin
            round_sat = (r >= 45'h0_8000_0000) ? 32'sh8000_0000 : $signed(nr);
        end else begin
            round_sat = (r > 45'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r[31:0]);
        end
    endfunction

    // stage 0: raw Z product and pixel offsets
    logic [39:0] zq_reg;
    logic [15:0] mag_x_reg, mag_y_reg;
    logic [2:0]  neg_reg;   // [k]: x sign at stage k; y sign kept separately
    logic [2:0]  negy_reg;
    logic [16:0] off_x_next, off_y_next;
    pose_wr_t    pw_reg [4];

    // stage 1: lateral products, rounded Z
    logic [55:0] px_reg, py_reg;
    logic [31:0] camz1_reg;
    logic [32:0] zr_next;

    // stage 2: products with the focal reciprocals
    logic [55:0] xl_reg, yl_reg;
    logic [47:0] xh_reg, yh_reg;
    logic [31:0] camz2_reg;

    // stage 3: camera point
    logic signed [31:0] camx_reg, camy_reg;
    logic [31:0]        camz3_reg;

    assign off_x_next = pix_offset({pixel_col, 4'b0000}, cfg.center_x);
    assign off_y_next = pix_offset({1'b0, pixel_row, 4'b0000}, cfg.center_y);
    assign zr_next    = 33'((zq_reg + 40'd128) >> 8);

    always_ff @(posedge aclk) begin
        if (ctl.adv[0]) begin
            zq_reg      <= 40'(depth_raw) * 40'(cfg.inv_depth_scale);
            mag_x_reg   <= off_x_next[15:0];
            mag_y_reg   <= off_y_next[15:0];
            neg_reg[0]  <= off_x_next[16];
            negy_reg[0] <= off_y_next[16];
            pw_reg[0]   <= pw_in;
        end
        if (ctl.adv[1]) begin
            px_reg      <= 56'(zq_reg) * 56'(mag_x_reg);
            py_reg      <= 56'(zq_reg) * 56'(mag_y_reg);
            camz1_reg   <= (zr_next[32:31] != 2'b00) ? 32'h7FFF_FFFF : zr_next[31:0];
            neg_reg[1]  <= neg_reg[0];
            negy_reg[1] <= negy_reg[0];
            pw_reg[1]   <= pw_reg[0];
        end
        if (ctl.adv[2]) begin
            xl_reg      <= 56'(px_reg[31:0]) * 56'(cfg.inv_focal_x);
            xh_reg      <= 48'(px_reg[55:32]) * 48'(cfg.inv_focal_x);
            yl_reg      <= 56'(py_reg[31:0]) * 56'(cfg.inv_focal_y);
            yh_reg      <= 48'(py_reg[55:32]) * 48'(cfg.inv_focal_y);
            camz2_reg   <= camz1_reg;
            neg_reg[2]  <= neg_reg[1];
            negy_reg[2] <= negy_reg[1];
            pw_reg[2]   <= pw_reg[1];
        end
        if (ctl.adv[3]) begin
            camx_reg  <= round_sat(xh_reg, xl_reg, neg_reg[2]);
            camy_reg  <= round_sat(yh_reg, yl_reg, negy_reg[2]);
            camz3_reg <= camz2_reg;
            pw_reg[3] <= pw_reg[2];
        end
    end

    assign cam_x  = camx_reg;
    assign cam_y  = camy_reg;
    assign cam_z  = $signed(camz3_reg);
    assign pw_out = pw_reg[3];

endmodule
`default_nettype wire

// File: design/dpw_world.sv
`timescale 1ns / 1ps
`default_nettype none
module dpw_world (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire dpw_pkg::pipe_ctl_t      ctl,
    input  wire dpw_pkg::pose_wr_t       pw,
    input  wire logic signed [31:0]      cam_x,
    input  wire logic signed [31:0]      cam_y,
    input  wire logic signed [31:0]      cam_z,
    output logic signed [31:0]           out_cam_x,
    output logic signed [31:0]           out_cam_y,
    output logic signed [31:0]           out_cam_z,
    output logic signed [31:0]           world_x,
    output logic signed [31:0]           world_y,
    output logic signed [31:0]           world_z
);
    import dpw_pkg::*;

    logic signed [31:0] pose_reg [POSE_WORDS];
    logic signed [31:0] cam_in [3];

    // stage 4: rotation products, translation
    logic signed [63:0] prod_reg [9];
    logic signed [31:0] t_reg [3];
    logic signed [31:0] cam4_reg [3];

    // stage 5: partial sums
    logic signed [64:0] sa_reg [3];
    logic signed [65:0] sb_reg [3];
    logic signed [31:0] cam5_reg [3];

    // stage 6: output
    logic signed [31:0] world_reg [3];
    logic signed [31:0] cam6_reg [3];
    logic signed [31:0] world_next [3];

    assign cam_in[0] = cam_x;
    assign cam_in[1] = cam_y;
    assign cam_in[2] = cam_z;

    // commit a pose word as its transfer passes the stage that reads the pose
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < POSE_WORDS; k++) begin
                pose_reg[k] <= '0;
            end
        end else if (ctl.adv[4] && ctl.vld[3] && pw.wr) begin
            pose_reg[pw.idx] <= $signed(pw.value);
        end
    end

    always_comb begin
        logic signed [66:0] s;
        logic [36:0]        q;
        for (int i = 0; i < 3; i++) begin
            s = 67'(sa_reg[i]) + 67'(sb_reg[i]);
            q = s[66:30];
            if (q[36:31] == {6{q[31]}}) begin
                world_next[i] = $signed(q[31:0]);
            end else begin
                world_next[i] = q[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv[4]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i*3+j] <= 64'(pose_reg[i*3+j]) * 64'(cam_in[j]);
                end
                t_reg[i]    <= pose_reg[9+i];
                cam4_reg[i] <= cam_in[i];
            end
        end
        if (ctl.adv[5]) begin
            for (int i = 0; i < 3; i++) begin
                sa_reg[i]   <= 65'(prod_reg[i*3]) + 65'(prod_reg[i*3+1]);
                sb_reg[i]   <= 66'(prod_reg[i*3+2])
                             + $signed({{4{t_reg[i][31]}}, t_reg[i], 30'd0})
                             + 66'sd536870912;
                cam5_reg[i] <= cam4_reg[i];
            end
        end
        if (ctl.adv[6]) begin
            for (int i = 0; i < 3; i++) begin
                world_reg[i] <= world_next[i];
                cam6_reg[i]  <= cam5_reg[i];
            end
        end
    end

    assign out_cam_x = cam6_reg[0];
    assign out_cam_y = cam6_reg[1];
    assign out_cam_z = cam6_reg[2];
    assign world_x   = world_reg[0];
    assign world_y   = world_reg[1];
    assign world_z   = world_reg[2];

endmodule
`default_nettype wire

// File: design/depth_pixel_to_world_point.sv
// Throughput: one transfer per cycle while m_tready does not stall the output; a
// seven-stage pipeline whose stages each advance when empty or when the stage after
// them moves, so bubbles close up.
// Pose-word and out-of-image transfers give no result.
// Reset (aresetn low, synchronous): pipeline empty, registers at defaults, pose zero.
`timescale 1ns / 1ps
`default_nettype none
`include "depth_pixel_to_world_point_defines.svh"
module depth_pixel_to_world_point #(
    parameter int IMAGE_WIDTH  = dpw_pkg::IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = dpw_pkg::IMAGE_HEIGHT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pose_index[3:0], pose_value[35:4], depth_raw[51:36],
    // pixel_col[61:52], pixel_row[70:62], zero pad[71]
    input  wire logic [71:0]  s_tdata,
    input  wire logic         s_tuser,   // operation
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // cam_x[31:0], cam_y[63:32], cam_z[95:64],
    // world_x[127:96], world_y[159:128], world_z[191:160]
    output logic [191:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [23:0]  cfg_data
);
    import dpw_pkg::*;

    logic [3:0]  pose_index;
    logic [31:0] pose_value;
    logic [15:0] depth_raw;
    logic [9:0]  pixel_col;
    logic [8:0]  pixel_row;

    cam_cfg_t    cfg_reg;
    pipe_ctl_t   ctl;
    pose_wr_t    pw_in, pw_mid;
    logic [STAGES-1:0] vld_reg, vld_next;
    logic        keep;

    logic signed [31:0] cx3, cy3, cz3;
    logic signed [31:0] cx6, cy6, cz6, wx6, wy6, wz6;

    assign pose_index = s_tdata[3:0];
    assign pose_value = s_tdata[35:4];
    assign depth_raw  = s_tdata[51:36];
    assign pixel_col  = s_tdata[61:52];
    assign pixel_row  = s_tdata[70:62];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inv_focal_x     <= RST_INV_FOCAL;
            cfg_reg.inv_focal_y     <= RST_INV_FOCAL;
            cfg_reg.center_x        <= RST_CENTER_X;
            cfg_reg.center_y        <= RST_CENTER_Y;
            cfg_reg.inv_depth_scale <= RST_INV_DEPTH_SCL;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_INV_FOCAL_X:     cfg_reg.inv_focal_x     <= cfg_data;
                CFG_INV_FOCAL_Y:     cfg_reg.inv_focal_y     <= cfg_data;
                CFG_CENTER_X:        cfg_reg.center_x        <= cfg_data[15:0];
                CFG_CENTER_Y:        cfg_reg.center_y        <= cfg_data[15:0];
                CFG_INV_DEPTH_SCALE: cfg_reg.inv_depth_scale <= cfg_data;
                default: ;
            endcase
        end
    end

    // drop bad pose indexes and pixels outside the image at the door
    always_comb begin
        if (s_tuser == OP_POSE) begin
            keep = (pose_index < 4'(POSE_WORDS));
        end else begin
            keep = ({3'b000, pixel_col} < 13'(IMAGE_WIDTH))
                && ({4'b0000, pixel_row} < 13'(IMAGE_HEIGHT));
        end
    end

    assign pw_in.wr    = (s_tuser == OP_POSE);
    assign pw_in.idx   = pose_index;
    assign pw_in.value = pose_value;

    always_comb begin
        ctl.vld            = vld_reg;
        ctl.adv[STAGES-1]  = !vld_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            ctl.adv[k] = !vld_reg[k] || ctl.adv[k+1];
        end
    end

    assign s_tready = ctl.adv[0];

    always_comb begin
        vld_next = vld_reg;
        if (ctl.adv[0]) begin
            vld_next[0] = s_tvalid && keep;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (ctl.adv[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
        // pose writes retire where they commit
        if (ctl.adv[4]) begin
            vld_next[4] = vld_reg[3] && !pw_mid.wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    dpw_cam u_cam (
        .aclk      (aclk),
        .ctl       (ctl),
        .cfg       (cfg_reg),
        .pw_in     (pw_in),
        .depth_raw (depth_raw),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .cam_x     (cx3),
        .cam_y     (cy3),
        .cam_z     (cz3),
        .pw_out    (pw_mid)
    );

    dpw_world u_world (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .pw        (pw_mid),
        .cam_x     (cx3),
        .cam_y     (cy3),
        .cam_z     (cz3),
        .out_cam_x (cx6),
        .out_cam_y (cy6),
        .out_cam_z (cz6),
        .world_x   (wx6),
        .world_y   (wy6),
        .world_z   (wz6)
    );

    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = {wz6, wy6, wx6, cz6, cy6, cx6};

    `DPW_ASSERT_NOW(a_full_when_blocked, !s_tready, &vld_reg,
        "input blocked while a pipeline stage is empty")
    `DPW_ASSERT_NOW(a_cam_z_nonneg, m_tvalid, !m_tdata[95],
        "camera Z negative on output")
    `DPW_ASSERT_NEXT(a_stage3_holds, vld_reg[3] && !ctl.adv[3], vld_reg[3],
        "stalled stage lost its item")

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import dpw_pkg::*;

    localparam int CFG_SLOTS   = 8;
    localparam int DRAIN_LIMIT = 4000;
    localparam logic signed [95:0] WORLD_MAX = 96'sh7FFF_FFFF;
    localparam logic signed [95:0] WORLD_MIN = -96'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] world_z;
        logic signed [31:0] world_y;
        logic signed [31:0] world_x;
        logic signed [31:0] cam_z;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_x;
    } point_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata   = '0;
    logic         s_tuser   = OP_PIXEL;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [191:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = CFG_INV_FOCAL_X;
    logic [23:0]  cfg_data  = '0;

    // camera registers and pose as the block should hold them
    cam_cfg_t cam_model = '{RST_INV_FOCAL, RST_INV_FOCAL, RST_CENTER_X, RST_CENTER_Y,
                            RST_INV_DEPTH_SCL};
    logic signed [31:0] pose_model [POSE_WORDS] = '{default: '0};
    point_t expected_points [$];

    string field_names [6] = '{"cam_x", "cam_y", "cam_z", "world_x", "world_y", "world_z"};
    int    mismatches = 0;
    int    idle_pct   = 0;
    int    stall_pct  = 0;
    bit    sending    = 1'b0;

    depth_pixel_to_world_point dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Lateral offset: exact product over 2^36, half away from zero, saturated.
    function automatic logic signed [31:0] lateral_offset(input logic [63:0] zq,
                                                          input logic [15:0] pix,
                                                          input logic [15:0] center,
                                                          input logic [23:0] inv_f);
        int           offset;
        logic [127:0] mag;
        logic [127:0] scaled;
        offset = int'(pix) * 16 - int'(center);
        mag = (offset < 0) ? 128'(-offset) : 128'(offset);
        scaled = (128'(zq) * mag * 128'(inv_f) + (128'd1 << 35)) >> 36;
        if (offset < 0)
            return (scaled >= 128'h8000_0000) ? 32'sh8000_0000 : -scaled[31:0];
        return (scaled > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : scaled[31:0];
    endfunction

    function automatic point_t project_point(input logic [15:0] depth, input logic [9:0] col,
                                             input logic [8:0] row);
        logic [63:0]        zq;
        logic [63:0]        zr;
        logic signed [31:0] cam   [3];
        logic signed [31:0] world [3];
        logic signed [95:0] acc;
        logic signed [95:0] term_a;
        logic signed [95:0] term_b;
        point_t             p;
        zq = 64'(depth) * 64'(cam_model.inv_depth_scale);
        zr = (zq + 64'd128) >> 8;
        cam[2] = (zr > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : zr[31:0];
        cam[0] = lateral_offset(zq, 16'(col), cam_model.center_x, cam_model.inv_focal_x);
        cam[1] = lateral_offset(zq, 16'(row), cam_model.center_y, cam_model.inv_focal_y);
        for (int i = 0; i < 3; i++) begin
            acc = 96'sd1 <<< 29;
            for (int j = 0; j < 3; j++) begin
                term_a = pose_model[i * 3 + j];
                term_b = cam[j];
                acc = acc + term_a * term_b;
            end
            term_a = pose_model[9 + i];
            acc = (acc + (term_a <<< 30)) >>> 30;
            if (acc > WORLD_MAX)
                world[i] = 32'sh7FFF_FFFF;
            else if (acc < WORLD_MIN)
                world[i] = 32'sh8000_0000;
            else
                world[i] = acc[31:0];
        end
        p.cam_x   = cam[0];
        p.cam_y   = cam[1];
        p.cam_z   = cam[2];
        p.world_x = world[0];
        p.world_y = world[1];
        p.world_z = world[2];
        return p;
    endfunction

    always @(posedge aclk) begin : check_results
        logic [191:0] want_bits;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_points.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                want_bits = expected_points.pop_front();
                for (int f = 0; f < 6; f++) begin
                    if (m_tdata[32 * f +: 32] !== want_bits[32 * f +: 32])
                        report_mismatch($sformatf("%s got %0d expected %0d", field_names[f],
                                                  $signed(m_tdata[32 * f +: 32]),
                                                  $signed(want_bits[32 * f +: 32])));
                end
            end
        end
    end

    task automatic send_item(input logic op, input logic [3:0] idx, input logic [31:0] value,
                             input logic [15:0] depth, input logic [9:0] col,
                             input logic [8:0] row);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, row, col, depth, value, idx};
        sending = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (op == OP_POSE) begin
            if (idx < POSE_WORDS)
                pose_model[idx] = value;
        end else if (col < IMAGE_WIDTH && row < IMAGE_HEIGHT) begin
            expected_points.insert(expected_points.size(), project_point(depth, col, row));
        end
        // idle each following cycle with the phase's probability
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            sending = 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_pixel(input logic [15:0] depth, input logic [9:0] col,
                              input logic [8:0] row);
        send_item(OP_PIXEL, 4'($urandom), $urandom, depth, col, row);
    endtask

    task automatic send_pose(input logic [3:0] idx, input logic [31:0] value);
        send_item(OP_POSE, idx, value, 16'($urandom), 10'($urandom), 9'($urandom));
    endtask

    // Hold the input idle until every result is back, then let the pipe empty.
    task automatic settle();
        int waited = 0;
        if (sending) begin
            s_tvalid <= 1'b0;
            sending = 1'b0;
        end
        while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_points.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_points.size()));
            expected_points.delete();
        end
        repeat (STAGES + 3) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_register(input logic [2:0] index, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            CFG_INV_FOCAL_X:     cam_model.inv_focal_x     = value;
            CFG_INV_FOCAL_Y:     cam_model.inv_focal_y     = value;
            CFG_CENTER_X:        cam_model.center_x        = value[15:0];
            CFG_CENTER_Y:        cam_model.center_y        = value[15:0];
            CFG_INV_DEPTH_SCALE: cam_model.inv_depth_scale = value;
            default: ;
        endcase
    endtask

    task automatic program_camera(input logic [23:0] fx, input logic [23:0] fy,
                                  input logic [23:0] cx, input logic [23:0] cy,
                                  input logic [23:0] scale);
        write_register(CFG_INV_FOCAL_X, fx);
        write_register(CFG_INV_FOCAL_Y, fy);
        write_register(CFG_CENTER_X, cx);
        write_register(CFG_CENTER_Y, cy);
        write_register(CFG_INV_DEPTH_SCALE, scale);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] pick_inverse();
        if ($urandom_range(1))
            return 24'($urandom_range(16777, 167772));
        return 24'($urandom_range(1, 24'hFF_FFFF));
    endfunction

    // Defaults and a zero pose: the world point is zero whatever the camera point.
    task automatic test_reset_state();
        idle_pct  = 0;
        stall_pct = 0;
        send_pixel(16'd0, 10'd0, 9'd0);
        send_pixel(16'hFFFF, 10'(IMAGE_WIDTH - 1), 9'(IMAGE_HEIGHT - 1));
        settle();
    endtask

    task automatic test_pose_and_pixels();
        logic [31:0] words [POSE_WORDS] = '{
            32'h4000_0000, 32'h0000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'hC000_0000, 32'h1234_5678,
            32'h0000_0000, 32'h0000_0001, 32'h4000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        for (int k = 0; k < POSE_WORDS; k++)
            send_pose(4'(k), words[k]);
        // indexes past the pose table must leave it untouched
        send_pose(4'(POSE_WORDS), 32'hFFFF_FFFF);
        send_pose(4'hF, 32'h5A5A_5A5A);
        send_pixel(16'd0, 10'd5, 9'd7);
        send_pixel(16'hFFFF, 10'(IMAGE_WIDTH - 1), 9'(IMAGE_HEIGHT - 1));
        send_pixel(16'hFFFF, 10'd0, 9'd0);
        send_pixel(16'd1000, 10'd320, 9'd180);
        send_pixel(16'd1234, 10'(IMAGE_WIDTH), 9'd0);
        send_pixel(16'd1234, 10'h3FF, 9'h1FF);
        send_pixel(16'd1234, 10'd0, 9'(IMAGE_HEIGHT));
        settle();
    endtask

    task automatic test_config_extremes();
        program_camera(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        send_pixel(16'hFFFF, 10'd0, 9'd0);
        send_pixel(16'hFFFF, 10'(IMAGE_WIDTH - 1), 9'(IMAGE_HEIGHT - 1));
        settle();
        // unused register slots: writes must be dropped
        for (int k = CFG_INV_DEPTH_SCALE + 1; k < CFG_SLOTS; k++)
            write_register(3'(k), 24'($urandom));
        program_camera(24'd1, 24'd1, 24'd0, 24'd0, 24'd1);
        send_pixel(16'hFFFF, 10'(IMAGE_WIDTH - 1), 9'(IMAGE_HEIGHT - 1));
        send_pixel(16'd1, 10'd0, 9'd0);
        settle();
    endtask

    task automatic test_random_stream(input int count, input int send_idle,
                                      input int recv_stall, input bit reprogram);
        logic [3:0]  idx;
        logic [31:0] value;
        logic [15:0] depth;
        logic [9:0]  col;
        logic [8:0]  row;
        int          pick;
        int          done = 0;
        if (reprogram)
            program_camera(pick_inverse(), pick_inverse(), 24'($urandom), 24'($urandom),
                           pick_inverse());
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                idx = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(POSE_WORDS - 1));
                case ($urandom_range(2))
                    0:       value = $urandom;
                    1:       value = $urandom_range(32'h4000_0000);
                    default: value = -$urandom_range(32'h4000_0000);
                endcase
                send_pose(idx, value);
                if (idx < POSE_WORDS)
                    done++;
            end else if (pick < 20) begin
                if ($urandom_range(1)) begin
                    col = 10'($urandom_range(IMAGE_WIDTH, 1023));
                    row = 9'($urandom);
                end else begin
                    col = 10'($urandom);
                    row = 9'($urandom_range(IMAGE_HEIGHT, 511));
                end
                send_pixel(16'($urandom), col, row);
            end else begin
                case ($urandom_range(7))
                    0:       depth = 16'd0;
                    1:       depth = 16'hFFFF;
                    2, 3:    depth = 16'($urandom_range(4095));
                    default: depth = 16'($urandom);
                endcase
                send_pixel(depth, 10'($urandom_range(IMAGE_WIDTH - 1)),
                           9'($urandom_range(IMAGE_HEIGHT - 1)));
                done++;
            end
        end
        settle();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_pose_and_pixels();
        test_config_extremes();
        test_random_stream(97, 0, 0, 1'b1);
        test_random_stream(97, 46, 0, 1'b1);
        test_random_stream(97, 0, 46, 1'b1);
        program_camera(RST_INV_FOCAL, RST_INV_FOCAL, RST_CENTER_X, RST_CENTER_Y,
                       RST_INV_DEPTH_SCL);
        test_random_stream(97, 20, 20, 1'b0);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
